>>> hdl/cdll_pkg.sv
// Package: sizes, codes, and shared types for the circular doubly linked list engine.
`timescale 1ns / 1ps
package cdll_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OCC_W      = 7;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    KIND_INSERT    = 2'd0,
    KIND_DEL_HEAD  = 2'd1,
    KIND_DEL_TAIL  = 2'd2,
    KIND_DEL_MATCH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    idx_t  rd_addr;
    logic  val_we;
    idx_t  val_addr;
    data_t val_data;
    logic  nxt_we;
    idx_t  nxt_addr;
    idx_t  nxt_data;
    logic  prv_we;
    idx_t  prv_addr;
    idx_t  prv_data;
  } mem_cmd_t;

  typedef struct packed {
    data_t value;
    idx_t  nxt;
    idx_t  prv;
  } node_rd_t;

  typedef struct packed {
    logic alloc_en;
    idx_t alloc_idx;
    logic release_en;
    idx_t release_idx;
  } free_cmd_t;

  function automatic data_t to_data(logic [VALUE_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] to_out(data_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[VALUE_W-1:0];
  endfunction

endpackage

>>> hdl/cdll_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface cdll_req_if;
  logic                                valid;
  logic                                ready;
  cdll_pkg::kind_e                     kind;
  logic signed [cdll_pkg::VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface cdll_rsp_if;
  logic                                valid;
  logic                                ready;
  cdll_pkg::status_e                   status;
  logic signed [cdll_pkg::VALUE_W-1:0] removed_value;
  logic [cdll_pkg::OCC_W-1:0]          occupancy;

  modport source (output valid, status, removed_value, occupancy, input ready);
  modport sink   (input valid, status, removed_value, occupancy, output ready);
endinterface

>>> hdl/circular_doubly_linked_list_engine_top.sv
// Top level of the circular doubly linked list engine.
`timescale 1ns / 1ps
// Keeps a circular doubly linked list of up to 64 values in three node RAMs
// (value, next link, previous link) with a flip-flop free map; inserts take
// the lowest free slot. One request is worked at a time; a new request is
// taken while the previous response still waits in the output register.
// Full and empty requests go straight to the response state; delete by value
// walks the next links one RAM read per cycle and stops at the first match or
// after visiting every node. No clearing pass is needed after reset.
module circular_doubly_linked_list_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdll_req_if.sink   req_i,
  cdll_rsp_if.source rsp_o
);
  import cdll_pkg::*;

  mem_cmd_t  mem_cmd;
  node_rd_t  node_rd;
  free_cmd_t free_cmd;
  idx_t      free_slot;

  cdll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .node_rd_i   (node_rd),
    .free_slot_i (free_slot),
    .mem_cmd_o   (mem_cmd),
    .free_cmd_o  (free_cmd)
  );

  cdll_free_map u_free_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .free_cmd_i  (free_cmd),
    .free_slot_o (free_slot)
  );

  cdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (mem_cmd.val_we),
    .waddr_i (mem_cmd.val_addr),
    .wdata_i (mem_cmd.val_data),
    .raddr_i (mem_cmd.rd_addr),
    .rdata_o (node_rd.value)
  );

  cdll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (mem_cmd.nxt_we),
    .waddr_i (mem_cmd.nxt_addr),
    .wdata_i (mem_cmd.nxt_data),
    .raddr_i (mem_cmd.rd_addr),
    .rdata_o (node_rd.nxt)
  );

  cdll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (mem_cmd.prv_we),
    .waddr_i (mem_cmd.prv_addr),
    .wdata_i (mem_cmd.prv_data),
    .raddr_i (mem_cmd.rd_addr),
    .rdata_o (node_rd.prv)
  );

endmodule

>>> hdl/cdll_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cdll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/cdll_free_map.sv
// Free slot map with a two-stage registered lowest-free-slot search.
`timescale 1ns / 1ps
module cdll_free_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdll_pkg::free_cmd_t free_cmd_i,
  output cdll_pkg::idx_t      free_slot_o
);
  import cdll_pkg::*;

  localparam int unsigned GRP   = 8;
  localparam int unsigned GRP_W = 3;
  localparam int unsigned NGRP  = (CAPACITY + GRP - 1) / GRP;
  localparam int unsigned SW    = GRP_W + ((NGRP > 1) ? $clog2(NGRP) : 1);

  logic [CAPACITY-1:0]   free_q;
  logic [NGRP*GRP-1:0]   free_pad;
  logic [NGRP-1:0]       grp_any_q;
  logic [GRP_W-1:0]      grp_low_d [NGRP];
  logic [GRP_W-1:0]      grp_low_q [NGRP];
  logic [SW-1:0]         slot_d;
  logic [SW-1:0]         slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else begin
      if (free_cmd_i.alloc_en) begin
        free_q[free_cmd_i.alloc_idx] <= 1'b0;
      end
      if (free_cmd_i.release_en) begin
        free_q[free_cmd_i.release_idx] <= 1'b1;
      end
    end
  end

  assign free_pad = (NGRP*GRP)'(free_q);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_low_d[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (free_pad[g*GRP + j]) begin
          grp_low_d[g] = GRP_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_q[g] <= |free_pad[g*GRP +: GRP];
      grp_low_q[g] <= grp_low_d[g];
    end
  end

  always_comb begin
    slot_d = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        slot_d = (SW'(g) << GRP_W) | SW'(grp_low_q[g]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign free_slot_o = IDX_W'(slot_q);

endmodule

>>> hdl/cdll_ctrl.sv
// Request sequencer: reads, links and unlinks nodes in the node memories.
`timescale 1ns / 1ps
module cdll_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  cdll_req_if.sink            req_i,
  cdll_rsp_if.source          rsp_o,
  input  cdll_pkg::node_rd_t  node_rd_i,
  input  cdll_pkg::idx_t      free_slot_i,
  output cdll_pkg::mem_cmd_t  mem_cmd_o,
  output cdll_pkg::free_cmd_t free_cmd_o
);
  import cdll_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_INS_W1,
    S_INS_W2,
    S_TAIL_RD,
    S_NODE_RD,
    S_WALK,
    S_UNLINK,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  idx_t                head_q, head_d;
  cnt_t                count_q, count_d;
  data_t               val_q, val_d;
  idx_t                t_q, t_d;
  idx_t                s_q, s_d;
  idx_t                n_q, n_d;
  idx_t                p_q, p_d;
  idx_t                nq_q, nq_d;
  data_t               v_q, v_d;
  cnt_t                steps_q, steps_d;
  status_e             res_st_q, res_st_d;
  logic [VALUE_W-1:0]  res_val_q, res_val_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_st_q, out_st_d;
  logic [VALUE_W-1:0]  out_val_q, out_val_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    val_d       = val_q;
    t_d         = t_q;
    s_d         = s_q;
    n_d         = n_q;
    p_d         = p_q;
    nq_d        = nq_q;
    v_d         = v_q;
    steps_d     = steps_q;
    res_st_d    = res_st_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_val_d   = out_val_q;
    out_occ_d   = out_occ_q;
    mem_cmd_o   = '0;
    mem_cmd_o.rd_addr = head_q;
    free_cmd_o  = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          val_d     = to_data(req_i.value);
          res_val_d = '0;
          n_d       = head_q;
          steps_d   = '0;
          if (req_i.kind == KIND_INSERT) begin
            if (count_q == cnt_t'(CAPACITY)) begin
              res_st_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              state_d = S_SRCH;
            end
          end else if (count_q == '0) begin
            res_st_d = ST_EMPTY;
            state_d  = S_RESP;
          end else begin
            case (req_i.kind)
              KIND_DEL_HEAD:  state_d = S_NODE_RD;
              KIND_DEL_TAIL:  state_d = S_TAIL_RD;
              KIND_DEL_MATCH: state_d = S_WALK;
              default:        state_d = S_RESP;
            endcase
          end
        end
      end
      S_SRCH: begin
        t_d     = node_rd_i.prv;
        state_d = S_INS_W1;
      end
      S_INS_W1: begin
        s_d = free_slot_i;
        mem_cmd_o.val_we   = 1'b1;
        mem_cmd_o.val_addr = free_slot_i;
        mem_cmd_o.val_data = val_q;
        mem_cmd_o.nxt_we   = 1'b1;
        mem_cmd_o.nxt_addr = free_slot_i;
        mem_cmd_o.prv_we   = 1'b1;
        mem_cmd_o.prv_addr = free_slot_i;
        free_cmd_o.alloc_en  = 1'b1;
        free_cmd_o.alloc_idx = free_slot_i;
        res_st_d = ST_OK;
        if (count_q == '0) begin
          mem_cmd_o.nxt_data = free_slot_i;
          mem_cmd_o.prv_data = free_slot_i;
          head_d  = free_slot_i;
          count_d = count_q + cnt_t'(1);
          state_d = S_RESP;
        end else begin
          mem_cmd_o.nxt_data = head_q;
          mem_cmd_o.prv_data = t_q;
          state_d = S_INS_W2;
        end
      end
      S_INS_W2: begin
        mem_cmd_o.nxt_we   = 1'b1;
        mem_cmd_o.nxt_addr = t_q;
        mem_cmd_o.nxt_data = s_q;
        mem_cmd_o.prv_we   = 1'b1;
        mem_cmd_o.prv_addr = head_q;
        mem_cmd_o.prv_data = s_q;
        head_d  = s_q;
        count_d = count_q + cnt_t'(1);
        state_d = S_RESP;
      end
      S_TAIL_RD: begin
        n_d = node_rd_i.prv;
        mem_cmd_o.rd_addr = node_rd_i.prv;
        state_d = S_NODE_RD;
      end
      S_NODE_RD: begin
        p_d     = node_rd_i.prv;
        nq_d    = node_rd_i.nxt;
        v_d     = node_rd_i.value;
        state_d = S_UNLINK;
      end
      S_WALK: begin
        if (node_rd_i.value == val_q) begin
          p_d     = node_rd_i.prv;
          nq_d    = node_rd_i.nxt;
          v_d     = node_rd_i.value;
          state_d = S_UNLINK;
        end else if (steps_q + cnt_t'(1) == count_q) begin
          res_st_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          mem_cmd_o.rd_addr = node_rd_i.nxt;
          n_d     = node_rd_i.nxt;
          steps_d = steps_q + cnt_t'(1);
        end
      end
      S_UNLINK: begin
        free_cmd_o.release_en  = 1'b1;
        free_cmd_o.release_idx = n_q;
        res_st_d  = ST_OK;
        res_val_d = to_out(v_q);
        if (count_q <= cnt_t'(1)) begin
          count_d = '0;
        end else begin
          mem_cmd_o.nxt_we   = 1'b1;
          mem_cmd_o.nxt_addr = p_q;
          mem_cmd_o.nxt_data = nq_q;
          mem_cmd_o.prv_we   = 1'b1;
          mem_cmd_o.prv_addr = nq_q;
          mem_cmd_o.prv_data = p_q;
          if (n_q == head_q) begin
            head_d = nq_q;
          end
          count_d = count_q - cnt_t'(1);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_val_d   = res_val_q;
          out_occ_d   = OCC_W'(count_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      val_q       <= '0;
      t_q         <= '0;
      s_q         <= '0;
      n_q         <= '0;
      p_q         <= '0;
      nq_q        <= '0;
      v_q         <= '0;
      steps_q     <= '0;
      res_st_q    <= ST_OK;
      res_val_q   <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_val_q   <= '0;
      out_occ_q   <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      val_q       <= val_d;
      t_q         <= t_d;
      s_q         <= s_d;
      n_q         <= n_d;
      p_q         <= p_d;
      nq_q        <= nq_d;
      v_q         <= v_d;
      steps_q     <= steps_d;
      res_st_q    <= res_st_d;
      res_val_q   <= res_val_d;
      out_valid_q <= out_valid_d;
      out_st_q    <= out_st_d;
      out_val_q   <= out_val_d;
      out_occ_q   <= out_occ_d;
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_st_q;
  assign rsp_o.removed_value = out_val_q;
  assign rsp_o.occupancy     = out_occ_q;

endmodule
